### hdl/sfplc_pkg.sv
// Package: item types, character codes and constants for the sensor frame parser.
package sfplc_pkg;

    localparam int MAX_CONTENT = 63;
    localparam int CNT_W       = $clog2(MAX_CONTENT + 1);
    localparam int CFG_IDX_W   = 2;

    // Operation codes of an input item
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_MANUAL = 2'd1;
    localparam logic [1:0] OP_RESUME = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_SENSOR = 2'd0;
    localparam logic [1:0] KIND_MANUAL = 2'd1;
    localparam logic [1:0] KIND_RESUME = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DARK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 2'd1;

    localparam logic signed [31:0] DARK_RESET   = 32'sd20;
    localparam logic signed [31:0] BRIGHT_RESET = 32'sd35;

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Parse stages: prefix match, then the three numbers, then done
    localparam logic [2:0] ST_P0    = 3'd0;
    localparam logic [2:0] ST_TEMP  = 3'd4;
    localparam logic [2:0] ST_HUMI  = 3'd5;
    localparam logic [2:0] ST_LIGHT = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    // Frame prefix "ENV,"
    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h45;
            2'd1:    ch = 8'h4E;
            2'd2:    ch = 8'h56;
            default: ch = CH_COMMA;
        endcase
        return ch;
    endfunction

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] temperature;
        logic signed [31:0] humidity;
        logic signed [31:0] light;
        logic               auto_mode;
        logic               night_mode;
        logic               led_command;
    } t_out_item;

endpackage

### hdl/sensor_frame_parser_light_control.sv
// Sensor frame parser with automatic night light control.
// Each accepted input item is held in the input register; its result is then
// loaded into the result register. Throughput: one item per cycle while the
// output is not stalled; the parse and update step is combinational logic.
// Reset (synchronous, active low) clears frame state, stored readings and
// the result valid flag, enables auto mode and restores the default thresholds.
module sensor_frame_parser_light_control (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sfplc_pkg::t_in_item               i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sfplc_pkg::t_out_item              o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sfplc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic                        r_in_valid;
    sfplc_pkg::t_in_item         r_in;
    logic                        r_out_valid;
    sfplc_pkg::t_out_item        r_out;

    logic signed [31:0]          r_dark, r_bright;

    logic                        r_in_frame, n_in_frame;
    logic [sfplc_pkg::CNT_W-1:0] r_count, n_count;
    logic [2:0]                  r_stage, n_stage;
    logic [31:0]                 r_accum, n_accum;
    logic                        r_negative, n_negative;
    logic                        r_digit_seen, n_digit_seen;
    logic                        r_sign_seen, n_sign_seen;
    logic                        r_failed, n_failed;
    logic                        r_ended, n_ended;
    logic [31:0]                 r_pend_temp, n_pend_temp;
    logic [31:0]                 r_pend_humi, n_pend_humi;
    logic [31:0]                 r_temp, n_temp;
    logic [31:0]                 r_humi, n_humi;
    logic [31:0]                 r_light, n_light;
    logic                        r_auto, n_auto;
    logic                        r_night, n_night;

    logic                        advance;
    logic                        n_res_valid;
    logic                        n_led;
    logic [1:0]                  n_kind;
    sfplc_pkg::t_out_item        n_res;

    logic [7:0]                  ch;
    logic                        is_digit, is_space;
    logic [35:0]                 acc_x10;
    logic [31:0]                 acc_sat;
    logic [31:0]                 num_val;

    function automatic logic [31:0] number_value(input logic [31:0] mag, input logic neg);
        logic [31:0] v;
        if (neg) begin
            v = 32'd0 - mag;
        end else if (mag > 32'h7FFF_FFFF) begin
            v = 32'h7FFF_FFFF;
        end else begin
            v = mag;
        end
        return v;
    endfunction

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign ch       = r_in.rx_byte;
    assign is_digit = (ch >= sfplc_pkg::CH_ZERO) && (ch <= sfplc_pkg::CH_NINE);
    assign is_space = (ch == sfplc_pkg::CH_SPACE) ||
                      ((ch >= sfplc_pkg::CH_TAB) && (ch <= sfplc_pkg::CH_CR));
    // Accumulate one decimal digit: accum * 10 + digit, clamp at 2^31
    assign acc_x10  = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + {32'd0, ch[3:0]};
    assign acc_sat  = (acc_x10 > 36'h0_8000_0000) ? 32'h8000_0000 : acc_x10[31:0];
    assign num_val  = number_value(r_accum, r_negative);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_count      = r_count;
        n_stage      = r_stage;
        n_accum      = r_accum;
        n_negative   = r_negative;
        n_digit_seen = r_digit_seen;
        n_sign_seen  = r_sign_seen;
        n_failed     = r_failed;
        n_ended      = r_ended;
        n_pend_temp  = r_pend_temp;
        n_pend_humi  = r_pend_humi;
        n_temp       = r_temp;
        n_humi       = r_humi;
        n_light      = r_light;
        n_auto       = r_auto;
        n_night      = r_night;
        n_res_valid  = 1'b0;
        n_led        = 1'b0;
        n_kind       = sfplc_pkg::KIND_SENSOR;

        if (advance) begin
            unique case (r_in.op)
                sfplc_pkg::OP_MANUAL: begin
                    n_auto      = 1'b0;
                    n_night     = !r_night;
                    n_led       = 1'b1;
                    n_kind      = sfplc_pkg::KIND_MANUAL;
                    n_res_valid = 1'b1;
                end
                sfplc_pkg::OP_RESUME: begin
                    n_auto      = 1'b1;
                    n_kind      = sfplc_pkg::KIND_RESUME;
                    n_res_valid = 1'b1;
                end
                sfplc_pkg::OP_BYTE: begin
                    if (!r_in_frame) begin
                        if (ch == sfplc_pkg::CH_DOLLAR) begin
                            n_in_frame   = 1'b1;
                            n_count      = '0;
                            n_stage      = sfplc_pkg::ST_P0;
                            n_failed     = 1'b0;
                            n_ended      = 1'b0;
                            n_accum      = '0;
                            n_negative   = 1'b0;
                            n_digit_seen = 1'b0;
                            n_sign_seen  = 1'b0;
                        end
                    end else if (ch != sfplc_pkg::CH_HASH) begin
                        // Drop content past the limit or after a zero byte
                        if (!r_ended &&
                            (r_count < sfplc_pkg::CNT_W'(sfplc_pkg::MAX_CONTENT))) begin
                            n_count = r_count + 1'b1;
                            if (ch == sfplc_pkg::CH_NUL) begin
                                n_ended = 1'b1;
                            end else if (!r_failed && (r_stage != sfplc_pkg::ST_DONE)) begin
                                if (r_stage < sfplc_pkg::ST_TEMP) begin
                                    if (ch == sfplc_pkg::prefix_char(r_stage[1:0])) begin
                                        n_stage = r_stage + 1'b1;
                                    end else begin
                                        n_failed = 1'b1;
                                    end
                                end else if (is_digit) begin
                                    n_accum      = acc_sat;
                                    n_digit_seen = 1'b1;
                                end else if (!r_digit_seen) begin
                                    if (!r_sign_seen && is_space) begin
                                        n_failed = 1'b0;
                                    end else if (!r_sign_seen &&
                                                 ((ch == sfplc_pkg::CH_PLUS) ||
                                                  (ch == sfplc_pkg::CH_MINUS))) begin
                                        n_sign_seen = 1'b1;
                                        n_negative  = (ch == sfplc_pkg::CH_MINUS);
                                    end else begin
                                        n_failed = 1'b1;
                                    end
                                end else if (r_stage == sfplc_pkg::ST_LIGHT) begin
                                    // Light value stays in the accumulator
                                    n_stage = sfplc_pkg::ST_DONE;
                                end else if (ch != sfplc_pkg::CH_COMMA) begin
                                    n_failed = 1'b1;
                                end else begin
                                    if (r_stage == sfplc_pkg::ST_TEMP) begin
                                        n_pend_temp = num_val;
                                    end else begin
                                        n_pend_humi = num_val;
                                    end
                                    n_stage      = r_stage + 1'b1;
                                    n_accum      = '0;
                                    n_negative   = 1'b0;
                                    n_digit_seen = 1'b0;
                                    n_sign_seen  = 1'b0;
                                end
                            end
                        end
                    end else begin
                        n_in_frame = 1'b0;
                        if (!r_failed && ((r_stage == sfplc_pkg::ST_DONE) ||
                            ((r_stage == sfplc_pkg::ST_LIGHT) && r_digit_seen))) begin
                            n_temp      = r_pend_temp;
                            n_humi      = r_pend_humi;
                            n_light     = num_val;
                            n_res_valid = 1'b1;
                            if (r_auto) begin
                                if (($signed(num_val) < r_dark) && !r_night) begin
                                    n_night = 1'b1;
                                    n_led   = 1'b1;
                                end else if (($signed(num_val) > r_bright) && r_night) begin
                                    n_night = 1'b0;
                                    n_led   = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_res_valid = 1'b0;
                end
            endcase
        end

        n_res.kind        = n_kind;
        n_res.temperature = n_temp;
        n_res.humidity    = n_humi;
        n_res.light       = n_light;
        n_res.auto_mode   = n_auto;
        n_res.night_mode  = n_night;
        n_res.led_command = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dark       <= sfplc_pkg::DARK_RESET;
            r_bright     <= sfplc_pkg::BRIGHT_RESET;
            r_in_frame   <= 1'b0;
            r_count      <= '0;
            r_stage      <= sfplc_pkg::ST_P0;
            r_accum      <= '0;
            r_negative   <= 1'b0;
            r_digit_seen <= 1'b0;
            r_sign_seen  <= 1'b0;
            r_failed     <= 1'b0;
            r_ended      <= 1'b0;
            r_pend_temp  <= '0;
            r_pend_humi  <= '0;
            r_temp       <= '0;
            r_humi       <= '0;
            r_light      <= '0;
            r_auto       <= 1'b1;
            r_night      <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= n_res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == sfplc_pkg::CFG_DARK) begin
                    r_dark <= $signed(i_cfg_data);
                end else if (i_cfg_index == sfplc_pkg::CFG_BRIGHT) begin
                    r_bright <= $signed(i_cfg_data);
                end
            end
            r_in_frame   <= n_in_frame;
            r_count      <= n_count;
            r_stage      <= n_stage;
            r_accum      <= n_accum;
            r_negative   <= n_negative;
            r_digit_seen <= n_digit_seen;
            r_sign_seen  <= n_sign_seen;
            r_failed     <= n_failed;
            r_ended      <= n_ended;
            r_pend_temp  <= n_pend_temp;
            r_pend_humi  <= n_pend_humi;
            r_temp       <= n_temp;
            r_humi       <= n_humi;
            r_light      <= n_light;
            r_auto       <= n_auto;
            r_night      <= n_night;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (advance && n_res_valid) begin
            r_out <= n_res;
        end
    end

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sfplc_pkg::CNT_W'(sfplc_pkg::MAX_CONTENT))
        else $error("content count past limit");

    a_manual_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == sfplc_pkg::KIND_MANUAL)
            |-> o_out.led_command && !o_out.auto_mode)
        else $error("manual toggle result without LED command");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == sfplc_pkg::KIND_RESUME)
            |-> o_out.auto_mode && !o_out.led_command)
        else $error("resume result malformed");

    a_hash_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_frame && (r_in.op == sfplc_pkg::OP_BYTE) &&
        (r_in.rx_byte == sfplc_pkg::CH_HASH) |=> !r_in_frame)
        else $error("frame not closed by hash");

    a_sensor_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == sfplc_pkg::KIND_SENSOR) && o_out.led_command
            |-> o_out.auto_mode)
        else $error("automatic LED command while in manual mode");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the sensor frame parser with light control.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [31:0] ENV_TAG   = "ENV,";
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            in_valid = 1'b0;
    logic                            in_ready;
    sfplc_pkg::t_in_item             in_item = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    sfplc_pkg::t_out_item            out_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sfplc_pkg::CFG_IDX_W-1:0] cfg_index = sfplc_pkg::CFG_DARK;
    logic [31:0]                     cfg_data = '0;

    int send_gap_pct = 0;
    int ready_stall_pct = 0;
    int mismatch_count = 0;

    sfplc_pkg::t_out_item sensor_reports_due[$];
    sfplc_pkg::t_out_item due_rep;

    // Frame tracker state
    logic               f_open = 1'b0;
    int                 f_count = 0;
    logic [2:0]         f_stage = sfplc_pkg::ST_P0;
    logic               f_bad = 1'b0;
    logic               f_ended = 1'b0;
    logic [31:0]        num_mag = '0;
    logic               num_neg = 1'b0;
    logic               num_digit = 1'b0;
    logic               num_sign = 1'b0;
    logic signed [31:0] hold_temp = '0;
    logic signed [31:0] hold_humi = '0;
    logic signed [31:0] cur_temp = '0;
    logic signed [31:0] cur_humi = '0;
    logic signed [31:0] cur_light = '0;
    logic               auto_on = 1'b1;
    logic               lamp_on = 1'b0;
    logic signed [31:0] thr_dark = sfplc_pkg::DARK_RESET;
    logic signed [31:0] thr_bright = sfplc_pkg::BRIGHT_RESET;

    sensor_frame_parser_light_control dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_number();
        num_mag   = '0;
        num_neg   = 1'b0;
        num_digit = 1'b0;
        num_sign  = 1'b0;
    endfunction

    // Saturate the magnitude to a signed 32-bit reading
    function automatic logic signed [31:0] num_value();
        if (num_neg)
            return 32'd0 - num_mag;
        return (num_mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_mag;
    endfunction

    function automatic sfplc_pkg::t_out_item make_report(input logic [1:0] kind,
                                                         input logic led);
        sfplc_pkg::t_out_item r;
        r.kind        = kind;
        r.temperature = cur_temp;
        r.humidity    = cur_humi;
        r.light       = cur_light;
        r.auto_mode   = auto_on;
        r.night_mode  = lamp_on;
        r.led_command = led;
        return r;
    endfunction

    // Advance the frame tracker by one item; return 1 when it yields a report
    function automatic bit track_sensor_frame(input sfplc_pkg::t_in_item it,
                                              output sfplc_pkg::t_out_item rep);
        logic [7:0]  c;
        logic [63:0] wide;
        logic        led;
        c   = it.rx_byte;
        led = 1'b0;
        rep = '0;
        if (it.op == sfplc_pkg::OP_MANUAL) begin
            auto_on = 1'b0;
            lamp_on = !lamp_on;
            rep = make_report(sfplc_pkg::KIND_MANUAL, 1'b1);
            return 1'b1;
        end
        if (it.op == sfplc_pkg::OP_RESUME) begin
            auto_on = 1'b1;
            rep = make_report(sfplc_pkg::KIND_RESUME, 1'b0);
            return 1'b1;
        end
        if (it.op != sfplc_pkg::OP_BYTE)
            return 1'b0;
        if (!f_open) begin
            if (c == sfplc_pkg::CH_DOLLAR) begin
                f_open  = 1'b1;
                f_count = 0;
                f_stage = sfplc_pkg::ST_P0;
                f_bad   = 1'b0;
                f_ended = 1'b0;
                clear_number();
            end
            return 1'b0;
        end
        if (c != sfplc_pkg::CH_HASH) begin
            if (f_ended || f_count >= sfplc_pkg::MAX_CONTENT)
                return 1'b0;
            f_count++;
            if (c == sfplc_pkg::CH_NUL) begin
                f_ended = 1'b1;
            end else if (!f_bad && f_stage != sfplc_pkg::ST_DONE) begin
                if (f_stage < sfplc_pkg::ST_TEMP) begin
                    if (c == ENV_TAG[8*(3 - f_stage) +: 8])
                        f_stage++;
                    else
                        f_bad = 1'b1;
                end else if (c >= sfplc_pkg::CH_ZERO && c <= sfplc_pkg::CH_NINE) begin
                    wide = 64'(num_mag) * 64'd10 + 64'(c - sfplc_pkg::CH_ZERO);
                    num_mag = (wide > 64'h8000_0000) ? 32'h8000_0000 : wide[31:0];
                    num_digit = 1'b1;
                end else if (!num_digit) begin
                    // leading whitespace, then at most one sign
                    if (!num_sign && (c == sfplc_pkg::CH_PLUS || c == sfplc_pkg::CH_MINUS)) begin
                        num_sign = 1'b1;
                        num_neg  = (c == sfplc_pkg::CH_MINUS);
                    end else if (num_sign ||
                                 !(c == sfplc_pkg::CH_SPACE ||
                                   (c >= sfplc_pkg::CH_TAB && c <= sfplc_pkg::CH_CR))) begin
                        f_bad = 1'b1;
                    end
                end else if (f_stage == sfplc_pkg::ST_LIGHT) begin
                    f_stage = sfplc_pkg::ST_DONE;
                end else if (c != sfplc_pkg::CH_COMMA) begin
                    f_bad = 1'b1;
                end else begin
                    if (f_stage == sfplc_pkg::ST_TEMP)
                        hold_temp = num_value();
                    else
                        hold_humi = num_value();
                    f_stage++;
                    clear_number();
                end
            end
            return 1'b0;
        end
        f_open = 1'b0;
        if (f_bad || !(f_stage == sfplc_pkg::ST_DONE ||
                       (f_stage == sfplc_pkg::ST_LIGHT && num_digit)))
            return 1'b0;
        cur_temp  = hold_temp;
        cur_humi  = hold_humi;
        cur_light = num_value();
        if (auto_on) begin
            if (cur_light < thr_dark && !lamp_on) begin
                lamp_on = 1'b1;
                led     = 1'b1;
            end else if (cur_light > thr_bright && lamp_on) begin
                lamp_on = 1'b0;
                led     = 1'b1;
            end
        end
        rep = make_report(sfplc_pkg::KIND_SENSOR, led);
        return 1'b1;
    endfunction

    function automatic void note_field(input string name, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Check each result against the oldest expected report; stall at random
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (sensor_reports_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d light %0d",
                             out_item.kind, out_item.light);
            end else begin
                due_rep = sensor_reports_due.pop_front();
                note_field("kind", due_rep.kind, out_item.kind);
                note_field("temperature", due_rep.temperature, out_item.temperature);
                note_field("humidity", due_rep.humidity, out_item.humidity);
                note_field("light", due_rep.light, out_item.light);
                note_field("auto_mode", due_rep.auto_mode, out_item.auto_mode);
                note_field("night_mode", due_rep.night_mode, out_item.night_mode);
                note_field("led_command", due_rep.led_command, out_item.led_command);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        sfplc_pkg::t_in_item  it;
        sfplc_pkg::t_out_item rep;
        it.op      = op;
        it.rx_byte = b;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (track_sensor_frame(it, rep))
            sensor_reports_due.push_back(rep);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_item(sfplc_pkg::OP_BYTE, s[i]);
    endtask

    // Hold the sender until every expected report is out and the pipe is empty
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        while (sensor_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_thresholds(input logic signed [31:0] dark,
                                    input logic signed [31:0] bright);
        for (int k = 0; k < 2; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (k == 0) ? sfplc_pkg::CFG_DARK : sfplc_pkg::CFG_BRIGHT;
            cfg_data  <= (k == 0) ? dark : bright;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        thr_dark   = dark;
        thr_bright = bright;
    endtask

    function automatic logic [7:0] any_but_hash();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == sfplc_pkg::CH_HASH) ? sfplc_pkg::CH_PLUS : b;
    endfunction

    // Append one decimal reading: optional whitespace and sign, then digits
    function automatic void push_reading(ref logic [7:0] q[$]);
        longint v;
        bit     huge;
        string  digits;
        huge = 1'b0;
        case ($urandom_range(0, 5))
            0: v = longint'($urandom_range(0, 70)) - 10;
            1: v = longint'(thr_dark) + longint'($urandom_range(0, 6)) - 3;
            2: v = longint'(thr_bright) + longint'($urandom_range(0, 6)) - 3;
            3: v = longint'($signed($urandom()));
            4: v = $urandom_range(0, 1) ? longint'(INT_MAX) : longint'(INT_MIN);
            default: begin
                huge = 1'b1;
                v = $urandom_range(0, 1) ? 1 : -1;
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                q.push_back(($urandom_range(0, 5) == 0)
                            ? sfplc_pkg::CH_SPACE
                            : 8'($urandom_range(sfplc_pkg::CH_TAB, sfplc_pkg::CH_CR)));
        if (v < 0)
            q.push_back(sfplc_pkg::CH_MINUS);
        else if ($urandom_range(0, 3) == 0)
            q.push_back(sfplc_pkg::CH_PLUS);
        if (huge) begin
            q.push_back(8'($urandom_range(sfplc_pkg::CH_ZERO + 1, sfplc_pkg::CH_NINE)));
            repeat ($urandom_range(9, 12))
                q.push_back(8'($urandom_range(sfplc_pkg::CH_ZERO, sfplc_pkg::CH_NINE)));
        end else begin
            if ($urandom_range(0, 7) == 0)
                q.push_back(sfplc_pkg::CH_ZERO);
            digits = $sformatf("%0d", (v < 0) ? -v : v);
            foreach (digits[i])
                q.push_back(digits[i]);
        end
    endfunction

    // Mostly well-formed ENV frames, some broken ones, events and line noise
    task automatic run_traffic(input int n_items);
        logic [7:0] frame[$];
        logic [7:0] b;
        int         pos;
        int         count;
        bit         paused;
        count  = 0;
        paused = 1'b0;
        while (count < n_items) begin
            case ($urandom_range(0, 19))
                0: begin
                    send_item(sfplc_pkg::OP_MANUAL, 8'($urandom()));
                    count++;
                end
                1: begin
                    send_item(sfplc_pkg::OP_RESUME, 8'($urandom()));
                    count++;
                end
                2: send_item(OP_UNUSED, 8'($urandom()));
                3, 4: begin
                    repeat ($urandom_range(1, 3)) begin
                        b = 8'($urandom_range(0, 255));
                        send_item(sfplc_pkg::OP_BYTE,
                                  (b == sfplc_pkg::CH_DOLLAR) ? sfplc_pkg::CH_HASH : b);
                    end
                end
                default: begin
                    frame = {};
                    frame.push_back(sfplc_pkg::CH_DOLLAR);
                    for (int k = 3; k >= 0; k--)
                        frame.push_back(ENV_TAG[8*k +: 8]);
                    for (int k = 0; k < 3; k++) begin
                        if (k != 0)
                            frame.push_back(sfplc_pkg::CH_COMMA);
                        push_reading(frame);
                    end
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 4))
                            frame.push_back(any_but_hash());
                    frame.push_back(sfplc_pkg::CH_HASH);
                    if ($urandom_range(0, 9) < 3) begin
                        pos = $urandom_range(1, frame.size() - 2);
                        case ($urandom_range(0, 5))
                            0: frame[pos] = any_but_hash();
                            1: frame.delete(pos);
                            2: frame.insert(pos, sfplc_pkg::CH_NUL);
                            // pad ahead of the first reading, sometimes past the content limit
                            3: repeat ($urandom_range(40, 70))
                                   frame.insert(5, sfplc_pkg::CH_SPACE);
                            4: repeat (60) frame.insert(frame.size() - 1, any_but_hash());
                            default: void'(frame.pop_back());
                        endcase
                    end
                    foreach (frame[i])
                        send_item(sfplc_pkg::OP_BYTE, frame[i]);
                    count += frame.size();
                end
            endcase
            if (!paused && count >= n_items / 2) begin
                wait_for_quiet();
                paused = 1'b1;
            end
        end
    endtask

    task automatic start_phase(input logic signed [31:0] dark, input logic signed [31:0] bright,
                               input int gap_pct, input int stall_pct);
        wait_for_quiet();
        write_thresholds(dark, bright);
        send_gap_pct    = gap_pct;
        ready_stall_pct = stall_pct;
    endtask

    task automatic test_directed_cases();
        send_item(OP_UNUSED, 8'hFF);
        send_item(sfplc_pkg::OP_BYTE, sfplc_pkg::CH_HASH);
        send_item(sfplc_pkg::OP_BYTE, 8'hFF);
        send_item(sfplc_pkg::OP_BYTE, sfplc_pkg::CH_NUL);
        send_text("$ENV,1,2,3#");
        send_text("$$#");
        send_item(sfplc_pkg::OP_MANUAL, 8'h00);
        send_item(sfplc_pkg::OP_RESUME, 8'hA5);
        send_text("$ENV#");
    endtask

    task automatic test_default_thresholds();
        start_phase(sfplc_pkg::DARK_RESET, sfplc_pkg::BRIGHT_RESET, 0, 0);
        run_traffic(270);
    endtask

    task automatic test_extreme_thresholds();
        start_phase(INT_MIN, INT_MAX, 56, 0);
        run_traffic(265);
    endtask

    task automatic test_inverted_thresholds();
        start_phase(INT_MAX, INT_MIN, 0, 56);
        run_traffic(265);
    endtask

    task automatic test_zero_thresholds();
        start_phase(32'sd0, 32'sd0, 11, 11);
        run_traffic(265);
    endtask

    task automatic test_random_thresholds();
        logic signed [31:0] dark;
        dark = int'($urandom_range(0, 100)) - 50;
        start_phase(dark, dark + int'($urandom_range(0, 40)), 0, 0);
        run_traffic(265);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_default_thresholds();
        test_extreme_thresholds();
        test_inverted_thresholds();
        test_zero_thresholds();
        test_random_thresholds();
        wait_for_quiet();
        if (mismatch_count == 0 && sensor_reports_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
